### hdl/bertlv_pkg.sv
// ---------------------------------------------------------------------------
// bertlv_pkg
// Shared types and codes for the BER-TLV stream parser.
// ---------------------------------------------------------------------------
package bertlv_pkg;

    localparam int DEF_MAX_TAG_BYTES = 4;
    localparam int DEF_MAX_LEN_BYTES = 4;

    localparam logic [2:0] EV_NONE = 3'd0;
    localparam logic [2:0] EV_TAG  = 3'd1;
    localparam logic [2:0] EV_LEN  = 3'd2;
    localparam logic [2:0] EV_VAL  = 3'd3;
    localparam logic [2:0] EV_ERR  = 3'd4;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_TRUNC = 2'd1;
    localparam logic [1:0] ERR_LONG  = 2'd2;

    localparam logic [7:0] CONS_MASK = 8'h20;
    localparam logic [7:0] TAG_MASK  = 8'h1F;
    localparam logic [7:0] MSB_MASK  = 8'h80;
    localparam logic [7:0] LOW_MASK  = 8'h7F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [31:0] tag_value;
        logic        constructed;
        logic [31:0] length_value;
        logic [7:0]  value_out;
        logic        value_last;
        logic [1:0]  error_code;
    } out_word_t;

endpackage

### hdl/bertlv_core.sv
// ---------------------------------------------------------------------------
// bertlv_core
// Parse state registers and the per-byte decode; one byte per step.
// ---------------------------------------------------------------------------
module bertlv_core #(
    parameter int MAX_TAG_BYTES = bertlv_pkg::DEF_MAX_TAG_BYTES,
    parameter int MAX_LEN_BYTES = bertlv_pkg::DEF_MAX_LEN_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  bertlv_pkg::in_word_t  in_word,
    output bertlv_pkg::out_word_t out_word
);

    localparam int TCW = $clog2(MAX_TAG_BYTES + 1);
    localparam int LLW = $clog2(MAX_LEN_BYTES + 1);

    localparam logic [2:0] PH_TAG0 = 3'd0;
    localparam logic [2:0] PH_TAGN = 3'd1;
    localparam logic [2:0] PH_LEN0 = 3'd2;
    localparam logic [2:0] PH_LENN = 3'd3;
    localparam logic [2:0] PH_VAL  = 3'd4;
    localparam logic [2:0] PH_SKIP = 3'd5;

    logic [2:0]     phase_reg, phase_next;
    logic [31:0]    tag_reg, tag_next;
    logic [TCW-1:0] tcnt_reg, tcnt_next;
    logic           cons_reg, cons_next;
    logic [31:0]    len_reg, len_next;
    logic [LLW-1:0] lleft_reg, lleft_next;
    logic [31:0]    vleft_reg, vleft_next;

    logic [7:0] b;
    logic       last;
    logic       do_tag, do_len, do_val, val_last, err;
    logic [1:0] err_code;
    logic       len_trunc;

    assign b    = in_word.data_byte;
    assign last = in_word.buffer_end;

    always_comb begin
        phase_next = phase_reg;
        tag_next   = tag_reg;
        tcnt_next  = tcnt_reg;
        cons_next  = cons_reg;
        len_next   = len_reg;
        lleft_next = lleft_reg;
        vleft_next = vleft_reg;
        do_tag     = 1'b0;
        do_len     = 1'b0;
        do_val     = 1'b0;
        val_last   = 1'b0;
        err        = 1'b0;
        err_code   = bertlv_pkg::ERR_NONE;
        unique case (phase_reg)
            PH_TAG0: begin
                tag_next  = {24'd0, b};
                tcnt_next = TCW'(1);
                cons_next = (b & bertlv_pkg::CONS_MASK) == bertlv_pkg::CONS_MASK;
                if ((b & bertlv_pkg::TAG_MASK) == bertlv_pkg::TAG_MASK) begin
                    if (last) begin
                        err      = 1'b1;
                        err_code = bertlv_pkg::ERR_TRUNC;
                    end else begin
                        phase_next = PH_TAGN;
                    end
                end else begin
                    do_tag = 1'b1;
                end
            end
            PH_TAGN: begin
                if (tcnt_reg >= TCW'(MAX_TAG_BYTES) || tag_reg[31:24] != 8'd0) begin
                    err      = 1'b1;
                    err_code = bertlv_pkg::ERR_LONG;
                end else begin
                    tag_next  = {tag_reg[23:0], b};
                    tcnt_next = tcnt_reg + TCW'(1);
                    if (b[7] && (b & bertlv_pkg::LOW_MASK) != 8'd0) begin
                        if (last) begin
                            err      = 1'b1;
                            err_code = bertlv_pkg::ERR_TRUNC;
                        end
                    end else begin
                        do_tag = 1'b1;
                    end
                end
            end
            PH_LEN0: begin
                len_next = 32'd0;
                if ((b & bertlv_pkg::MSB_MASK) == bertlv_pkg::MSB_MASK) begin
                    if (b[6:0] > 7'(MAX_LEN_BYTES)) begin
                        err      = 1'b1;
                        err_code = bertlv_pkg::ERR_LONG;
                    end else if (b[6:0] == 7'd0) begin
                        do_len = 1'b1;
                    end else if (last) begin
                        err      = 1'b1;
                        err_code = bertlv_pkg::ERR_TRUNC;
                    end else begin
                        lleft_next = LLW'(b[6:0]);
                        phase_next = PH_LENN;
                    end
                end else begin
                    len_next = {24'd0, b};
                    do_len   = 1'b1;
                end
            end
            PH_LENN: begin
                if (len_reg[31:24] != 8'd0) begin
                    err      = 1'b1;
                    err_code = bertlv_pkg::ERR_LONG;
                end else begin
                    len_next   = {len_reg[23:0], b};
                    lleft_next = lleft_reg - LLW'(1);
                    if (lleft_next == LLW'(0)) begin
                        do_len = 1'b1;
                    end else if (last) begin
                        err      = 1'b1;
                        err_code = bertlv_pkg::ERR_TRUNC;
                    end
                end
            end
            PH_VAL: begin
                vleft_next = vleft_reg - 32'd1;
                if (vleft_next == 32'd0) begin
                    do_val     = 1'b1;
                    val_last   = 1'b1;
                    phase_next = PH_TAG0;
                end else if (last) begin
                    err      = 1'b1;
                    err_code = bertlv_pkg::ERR_TRUNC;
                end else begin
                    do_val = 1'b1;
                end
            end
            default: begin
            end
        endcase

        // tag done / length done, with truncation check
        if (do_tag) begin
            if (last) begin
                do_tag   = 1'b0;
                err      = 1'b1;
                err_code = bertlv_pkg::ERR_TRUNC;
            end else begin
                phase_next = PH_LEN0;
            end
        end
        len_trunc = do_len && last && len_next != 32'd0;
        if (len_trunc) begin
            do_len   = 1'b0;
            err      = 1'b1;
            err_code = bertlv_pkg::ERR_TRUNC;
        end else if (do_len) begin
            vleft_next = len_next;
            phase_next = (len_next == 32'd0) ? PH_TAG0 : PH_VAL;
        end

        if (err) begin
            phase_next = PH_SKIP;
        end
        if (last) begin
            phase_next = PH_TAG0;
        end

        out_word              = '0;
        if (err) begin
            out_word.event_kind = bertlv_pkg::EV_ERR;
            out_word.error_code = err_code;
        end else if (do_tag) begin
            out_word.event_kind  = bertlv_pkg::EV_TAG;
            out_word.tag_value   = tag_next;
            out_word.constructed = cons_next;
        end else if (do_len) begin
            out_word.event_kind   = bertlv_pkg::EV_LEN;
            out_word.length_value = len_next;
        end else if (do_val) begin
            out_word.event_kind = bertlv_pkg::EV_VAL;
            out_word.value_out  = b;
            out_word.value_last = val_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TAG0;
            tag_reg   <= '0;
            tcnt_reg  <= '0;
            cons_reg  <= 1'b0;
            len_reg   <= '0;
            lleft_reg <= '0;
            vleft_reg <= '0;
        end else if (step) begin
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            tcnt_reg  <= tcnt_next;
            cons_reg  <= cons_next;
            len_reg   <= len_next;
            lleft_reg <= lleft_next;
            vleft_reg <= vleft_next;
        end
    end

endmodule

### hdl/bertlv_out_q.sv
// ---------------------------------------------------------------------------
// bertlv_out_q
// Two-entry result buffer; takes a new word while one waits downstream.
// ---------------------------------------------------------------------------
module bertlv_out_q (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  bertlv_pkg::out_word_t wr_word,
    output logic                  wr_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bertlv_pkg::out_word_t m_data
);

    bertlv_pkg::out_word_t mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wptr_reg, rptr_reg;
    logic       rd_en;

    assign wr_ready = cnt_reg != 2'd2;
    assign m_valid  = cnt_reg != 2'd0;
    assign m_data   = mem_reg[rptr_reg];
    assign rd_en    = m_valid && m_ready;

    always_comb begin
        cnt_next = cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wptr_reg] <= wr_word;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 2'd0;
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (wr_en) begin
                wptr_reg <= ~wptr_reg;
            end
            if (rd_en) begin
                rptr_reg <= ~rptr_reg;
            end
        end
    end

endmodule

### hdl/ber_tlv_stream_parser.sv
// ---------------------------------------------------------------------------
// ber_tlv_stream_parser
// BER-TLV byte stream parser: one result word per input byte.
// Each result word is written into the buffer as its byte is accepted and is valid from the next cycle.
// Throughput: one byte per cycle while the result buffer has room; the decode step is combinational.
// A two-entry result buffer keeps input flowing while a result waits.
// Reset: synchronous active-low aresetn; parser expects a tag, buffer empty.
// ---------------------------------------------------------------------------
module ber_tlv_stream_parser #(
    parameter int MAX_TAG_BYTES = bertlv_pkg::DEF_MAX_TAG_BYTES,
    parameter int MAX_LEN_BYTES = bertlv_pkg::DEF_MAX_LEN_BYTES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  bertlv_pkg::in_word_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output bertlv_pkg::out_word_t m_data
);

    logic                  step;
    bertlv_pkg::out_word_t res_word;

    assign step = s_valid && s_ready;

    bertlv_core #(
        .MAX_TAG_BYTES(MAX_TAG_BYTES),
        .MAX_LEN_BYTES(MAX_LEN_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_word (s_data),
        .out_word(res_word)
    );

    bertlv_out_q u_out_q (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (step),
        .wr_word (res_word),
        .wr_ready(s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
